// ----- design/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque: sizes, action and status
// codes, and the per-cycle command word broadcast to the storage cells.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_QUERY      = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    CMD_HOLD       = 2'd0,
    CMD_SHIFT_IN   = 2'd1,  // take the left neighbor's word (push front)
    CMD_SHIFT_OUT  = 2'd2,  // take the right neighbor's word (pop front)
    CMD_WRITE_BACK = 2'd3   // the cell at position count takes the new word
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                 cmd;
    logic signed [WORD_W-1:0]  word;
    logic        [CNT_W-1:0]   count;
  } cell_ctl_t;

endpackage

// ----- design/bounded_deque.sv -----
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed words kept in a chain of shifting cells.
// The result is strobed in the cycle after the operation is accepted.
// Throughput: one operation per cycle; busy never rises.
// The front word is always cell 0; pushes/pops at the front shift the chain.
// Reset (rst_n low, synchronous) empties the deque and drops any pending
// result; cell contents are not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
module bounded_deque (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic        [bdq_pkg::ACT_W-1:0]   in_action,
  input  logic signed [bdq_pkg::WORD_W-1:0]  in_push_value,
  output logic                               out_valid,
  output logic signed [bdq_pkg::WORD_W-1:0]  out_front_word,
  output logic signed [bdq_pkg::WORD_W-1:0]  out_back_word,
  output logic        [bdq_pkg::CNT_W-1:0]   out_entry_count,
  output logic                               out_is_empty,
  output logic        [bdq_pkg::STAT_W-1:0]  out_status
);
  import bdq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                    accept;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    valid_r;
  status_t                 status_r, status_nxt;
  cell_ctl_t               ctl;
  logic                    is_full, is_empty;

  logic signed [WORD_W-1:0] cell_word [DEPTH];
  logic signed [WORD_W-1:0] back_word;
  logic        [IDX_W-1:0]  back_idx;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  // decode the operation into a chain command, next count and status
  always_comb begin
    ctl.cmd    = CMD_HOLD;
    ctl.word   = in_push_value;
    ctl.count  = count_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (accept) begin
      unique case (in_action)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.cmd   = (in_action == ACT_PUSH_FRONT) ? CMD_SHIFT_IN : CMD_WRITE_BACK;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            ctl.cmd   = CMD_SHIFT_OUT;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        ACT_POP_BACK: begin
          if (is_empty) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          // query, and unused codes behave as query
          if (is_empty) begin
            status_nxt = ST_UNDERFLOW;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  // the chain: cell 0 shifts in the pushed word, the last cell's right input
  // is never used for a live word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = in_push_value;
    end else begin : g_mid
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_inner
      assign right_w = cell_word[i+1];
    end
    bdq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (IDX_W'(i)),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i])
    );
  end

  assign back_idx = IDX_W'(count_r - CNT_W'(1));

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (back_idx == IDX_W'(i)) begin
        back_word = cell_word[i];
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_entry_count = count_r;
  assign out_is_empty    = is_empty;
  assign out_status      = status_r;
  assign out_front_word  = is_empty ? '0 : cell_word[0];
  assign out_back_word   = is_empty ? '0 : back_word;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("word count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted operation gave no result");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_entry_count == FULL_CNT))
    else $error("push dropped while not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_UNDERFLOW) |-> out_is_empty)
    else $error("underflow reported on non-empty deque");
`endif

endmodule

// ----- design/bdq_cell.sv -----
// ----------------------------------------------------------------------------
// bdq_cell
// One storage slot of the deque. Position 0 is the front. The slot either
// holds, shifts in from its left neighbor, shifts in from its right neighbor,
// or captures the pushed word when it sits just past the back.
// ----------------------------------------------------------------------------
module bdq_cell (
  input  logic                               clk,
  input  bdq_pkg::cell_ctl_t                 ctl,
  input  logic        [bdq_pkg::IDX_W-1:0]   pos,
  input  logic signed [bdq_pkg::WORD_W-1:0]  left_word,
  input  logic signed [bdq_pkg::WORD_W-1:0]  right_word,
  output logic signed [bdq_pkg::WORD_W-1:0]  word
);
  import bdq_pkg::*;

  logic signed [WORD_W-1:0] data_r;
  logic signed [WORD_W-1:0] data_nxt;
  logic                     at_tail;

  assign at_tail = ({{(CNT_W-IDX_W){1'b0}}, pos} == ctl.count);

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.cmd)
      CMD_HOLD:       data_nxt = data_r;
      CMD_SHIFT_IN:   data_nxt = left_word;
      CMD_SHIFT_OUT:  data_nxt = right_word;
      CMD_WRITE_BACK: if (at_tail) begin
        data_nxt = ctl.word;
      end
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign word = data_r;

endmodule
